[rtl/core/mmdh_pkg.sv]
package mmdh_pkg;

    // store geometry
    localparam int CAPACITY = 256;
    localparam int HALF     = CAPACITY / 2;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int HALF_W   = $clog2(HALF);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int TIME_W = 31;
    localparam int TEMP_W = 16;
    localparam int PWR_W  = 7;
    localparam int REV_W  = 32;

    // operation codes
    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    // limits
    localparam logic [PWR_W-1:0]         POWER_MAX    = PWR_W'(100);
    localparam logic signed [TEMP_W-1:0] TEMP_NEG_RAW = 16'sh8000;
    localparam logic signed [TEMP_W-1:0] TEMP_FLOOR   = -16'sd32767;
    localparam logic [TIME_W-1:0]        RES_LIMIT    = 31'h4000_0000;
    localparam logic [TIME_W-1:0]        RES_HALF     = 31'h2000_0000;
    localparam logic [TIME_W-1:0]        RES_INIT     = 31'd1;
    localparam logic [REV_W-1:0]         REV_INIT     = 32'd1;

    typedef struct packed {
        logic [TIME_W-1:0]        start_time;
        logic signed [TEMP_W-1:0] temp_high;
        logic signed [TEMP_W-1:0] temp_low;
        logic [PWR_W-1:0]         power_high;
        logic [PWR_W-1:0]         power_low;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
    } mem_req_t;

    typedef struct packed {
        logic              read_valid;
        entry_t            entry;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] resolution;
        logic [REV_W-1:0]  revision;
    } result_t;

endpackage

[rtl/core/mmdh_mem.sv]
module mmdh_mem (
    input  logic              clk,
    input  mmdh_pkg::mem_req_t req,
    output mmdh_pkg::entry_t   rd_data_a,
    output mmdh_pkg::entry_t   rd_data_b
);
    import mmdh_pkg::*;

    entry_t mem_array [CAPACITY];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[req.wr_addr] <= req.wr_data;
        end
        rd_a_reg <= mem_array[req.rd_addr_a];
        rd_b_reg <= mem_array[req.rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

[rtl/core/mmdh_ctrl.sv]
module mmdh_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic [mmdh_pkg::TIME_W-1:0]        sample_time,
    input  logic signed [mmdh_pkg::TEMP_W-1:0] temperature,
    input  logic [mmdh_pkg::PWR_W-1:0]         power_percent,
    input  logic [7:0]                        read_index,
    input  logic                              out_free,
    output logic                              rsp_valid,
    output mmdh_pkg::result_t                  result,
    output mmdh_pkg::mem_req_t                 mem_req,
    input  mmdh_pkg::entry_t                   rd_data_a,
    input  mmdh_pkg::entry_t                   rd_data_b
);
    import mmdh_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_MERGE  = 5'b00100,
        ST_OPEN   = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]   res_reg, res_next;
    logic [REV_W-1:0]    rev_reg, rev_next;
    logic                hit_reg, hit_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [HALF_W-1:0]   iss_reg, iss_next;
    logic [HALF_W-1:0]   wr_addr_reg, wr_addr_next;

    logic [1:0]               func_reg;
    logic [TIME_W-1:0]        time_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [PWR_W-1:0]         pwr_reg;
    entry_t                   entry_reg, entry_next;

    logic signed [TEMP_W-1:0] temp_sat;
    logic [PWR_W-1:0]         pwr_sat;
    logic signed [TIME_W:0]   time_diff;
    logic                     near;
    entry_t                   widened;
    entry_t                   merged;
    entry_t                   fresh;
    logic [CNT_W-1:0]         last_idx;

    // input saturation
    assign temp_sat = (temperature == TEMP_NEG_RAW) ? TEMP_FLOOR : temperature;
    assign pwr_sat  = (power_percent > POWER_MAX) ? POWER_MAX : power_percent;

    assign last_idx  = count_reg - CNT_W'(1);
    assign time_diff = $signed({1'b0, time_reg}) - $signed({1'b0, rd_data_a.start_time});
    assign near      = time_diff < $signed({1'b0, res_reg});

    always_comb
    begin
        widened = rd_data_a;
        if (temp_reg > rd_data_a.temp_high) widened.temp_high = temp_reg;
        if (temp_reg < rd_data_a.temp_low)  widened.temp_low  = temp_reg;
        if (pwr_reg > rd_data_a.power_high) widened.power_high = pwr_reg;
        if (pwr_reg < rd_data_a.power_low)  widened.power_low  = pwr_reg;
    end

    // pair merge: even entry keeps its start time
    always_comb
    begin
        merged = rd_data_a;
        if (rd_data_b.temp_high > rd_data_a.temp_high)   merged.temp_high  = rd_data_b.temp_high;
        if (rd_data_b.temp_low < rd_data_a.temp_low)     merged.temp_low   = rd_data_b.temp_low;
        if (rd_data_b.power_high > rd_data_a.power_high) merged.power_high = rd_data_b.power_high;
        if (rd_data_b.power_low < rd_data_a.power_low)   merged.power_low  = rd_data_b.power_low;
    end

    always_comb
    begin
        fresh.start_time = time_reg;
        fresh.temp_high  = temp_reg;
        fresh.temp_low   = temp_reg;
        fresh.power_high = pwr_reg;
        fresh.power_low  = pwr_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        rev_next     = rev_reg;
        hit_next     = hit_reg;
        wr_pend_next = wr_pend_reg;
        iss_next     = iss_reg;
        wr_addr_next = wr_addr_reg;
        entry_next   = entry_reg;

        mem_req.wr_en     = 1'b0;
        mem_req.wr_addr   = ADDR_W'(last_idx);
        mem_req.wr_data   = fresh;
        mem_req.rd_addr_a = (func == FUNC_READ) ? ADDR_W'(read_index) : ADDR_W'(last_idx);
        mem_req.rd_addr_b = ADDR_W'(last_idx);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    hit_next = 1'b0;
                    case (func)
                        FUNC_RECORD:
                        begin
                            state_next = (count_reg == '0) ? ST_OPEN : ST_LOOKUP;
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            res_next   = RES_INIT;
                            rev_next   = rev_reg + REV_W'(1);
                            state_next = ST_RESP;
                        end
                        FUNC_READ:
                        begin
                            hit_next   = CNT_W'(read_index) < count_reg;
                            state_next = (CNT_W'(read_index) < count_reg) ? ST_LOOKUP : ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (func_reg == FUNC_READ)
                begin
                    entry_next = rd_data_a;
                    state_next = ST_RESP;
                end
                else if (near)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = ADDR_W'(last_idx);
                    mem_req.wr_data = widened;
                    state_next      = ST_RESP;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    iss_next     = '0;
                    wr_pend_next = 1'b0;
                    state_next   = ST_MERGE;
                end
                else
                begin
                    state_next = ST_OPEN;
                end
            end
            ST_MERGE:
            begin
                // read pair k while writing merged pair k-1; write index trails reads
                mem_req.rd_addr_a = ADDR_W'({iss_reg, 1'b0});
                mem_req.rd_addr_b = ADDR_W'({iss_reg, 1'b1});
                iss_next          = iss_reg + HALF_W'(1);
                wr_pend_next      = 1'b1;
                wr_addr_next      = iss_reg;
                if (wr_pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = ADDR_W'(wr_addr_reg);
                    mem_req.wr_data = merged;
                    if (wr_addr_reg == HALF_W'(HALF - 1))
                    begin
                        wr_pend_next = 1'b0;
                        count_next   = CNT_W'(HALF);
                        res_next     = (res_reg >= RES_HALF) ? RES_LIMIT : {res_reg[TIME_W-2:0], 1'b0};
                        rev_next     = rev_reg + REV_W'(1);
                        state_next   = ST_OPEN;
                    end
                end
            end
            ST_OPEN:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ADDR_W'(count_reg);
                mem_req.wr_data = fresh;
                count_next      = count_reg + CNT_W'(1);
                state_next      = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            res_reg     <= RES_INIT;
            rev_reg     <= REV_INIT;
            hit_reg     <= 1'b0;
            wr_pend_reg <= 1'b0;
            iss_reg     <= '0;
            wr_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            res_reg     <= res_next;
            rev_reg     <= rev_next;
            hit_reg     <= hit_next;
            wr_pend_reg <= wr_pend_next;
            iss_reg     <= iss_next;
            wr_addr_reg <= wr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            func_reg <= func;
            time_reg <= sample_time;
            temp_reg <= temp_sat;
            pwr_reg  <= pwr_sat;
        end
        entry_reg <= entry_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_RESP);

    always_comb
    begin
        result.read_valid = hit_reg;
        result.entry      = hit_reg ? entry_reg : '0;
        result.count      = count_reg;
        result.resolution = res_reg;
        result.revision   = rev_reg;
    end

endmodule

[rtl/core/min_max_decimating_history.sv]
// min/max decimating history of timestamped temperature and power samples
//
// input channel (in_valid/in_ready): one beat is a command; func selects
// record sample, clear history or read bucket at read_index
// output channel (out_valid/out_ready): exactly one result beat per command,
// carrying the bucket read (zero unless read_valid), the bucket count, the
// current seconds per bucket and the history revision
// clear, unused code and out-of-range read go straight to the response
// state; in-range read and record into the current bucket pass the lookup
// state, record into an empty store passes the open state, and record
// opening a new bucket passes lookup and then open; when the store is full
// a new bucket first merges adjacent pairs, one pair per cycle through the
// two read ports of the bucket ram, between lookup and open; one command is
// in flight at a time, so the next is taken once the result is registered
// reset empties the history (count 0, resolution 1, revision 1); the bucket
// ram itself is not cleared, only entries below the count are ever read
// a stalled receiver holds the result in the output register; the next
// command is still taken and runs, waiting to deliver until the register frees
module min_max_decimating_history (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic [mmdh_pkg::TIME_W-1:0]        sample_time,
    input  logic signed [mmdh_pkg::TEMP_W-1:0] temperature,
    input  logic [mmdh_pkg::PWR_W-1:0]         power_percent,
    input  logic [7:0]                        read_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              read_valid,
    output logic [mmdh_pkg::TIME_W-1:0]        entry_time,
    output logic signed [mmdh_pkg::TEMP_W-1:0] entry_temp_high,
    output logic signed [mmdh_pkg::TEMP_W-1:0] entry_temp_low,
    output logic [mmdh_pkg::PWR_W-1:0]         entry_power_high,
    output logic [mmdh_pkg::PWR_W-1:0]         entry_power_low,
    output logic [mmdh_pkg::CNT_W-1:0]         bucket_count,
    output logic [mmdh_pkg::TIME_W-1:0]        seconds_per_bucket,
    output logic [mmdh_pkg::REV_W-1:0]         history_revision
);
    import mmdh_pkg::*;

    mem_req_t mem_req;
    entry_t   rd_data_a;
    entry_t   rd_data_b;
    result_t  result;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     rsp_valid;
    logic     out_free;
    logic     out_load;

    // output register is free when empty or draining this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = rsp_valid && out_free;

    mmdh_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .sample_time   (sample_time),
        .temperature   (temperature),
        .power_percent (power_percent),
        .read_index    (read_index),
        .out_free      (out_free),
        .rsp_valid     (rsp_valid),
        .result        (result),
        .mem_req       (mem_req),
        .rd_data_a     (rd_data_a),
        .rd_data_b     (rd_data_b)
    );

    // bucket ram: one write port, two registered read ports
    mmdh_mem u_mem (
        .clk       (clk),
        .req       (mem_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, held while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign read_valid         = out_reg.read_valid;
    assign entry_time         = out_reg.entry.start_time;
    assign entry_temp_high    = out_reg.entry.temp_high;
    assign entry_temp_low     = out_reg.entry.temp_low;
    assign entry_power_high   = out_reg.entry.power_high;
    assign entry_power_low    = out_reg.entry.power_low;
    assign bucket_count       = out_reg.count;
    assign seconds_per_bucket = out_reg.resolution;
    assign history_revision   = out_reg.revision;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import mmdh_pkg::*;

    // code 3 is not decoded by the block, it only reports status
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS      = 1700;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AFTER  = 300;
    localparam int DRAIN_CYCLES     = 16;

    localparam logic [TIME_W-1:0]        TIME_MAX  = '1;
    localparam logic signed [TEMP_W-1:0] TEMP_CEIL = 16'sd32767;

    // history predictor plus the queue of result beats still owed by the block
    class history_scoreboard;
        entry_t            buckets [CAPACITY];
        int unsigned       count;
        logic [TIME_W-1:0] res;
        logic [REV_W-1:0]  rev;
        result_t           owed_q [$];
        int unsigned       failures;
        int unsigned       accepted;

        function new();
            count    = 0;
            res      = RES_INIT;
            rev      = REV_INIT;
            failures = 0;
            accepted = 0;
        endfunction

        function void open_bucket(logic [TIME_W-1:0] t, logic signed [TEMP_W-1:0] tc,
                                  logic [PWR_W-1:0] pw);
            if (count >= CAPACITY)
                return;
            buckets[count].start_time = t;
            buckets[count].temp_high  = tc;
            buckets[count].temp_low   = tc;
            buckets[count].power_high = pw;
            buckets[count].power_low  = pw;
            count++;
        endfunction

        function void merge_pairs();
            entry_t lo_e;
            entry_t hi_e;
            for (int i = 0; i < HALF; i++) begin
                lo_e = buckets[2*i];
                hi_e = buckets[2*i+1];
                if ($signed(hi_e.temp_high) > $signed(lo_e.temp_high))
                    lo_e.temp_high = hi_e.temp_high;
                if ($signed(hi_e.temp_low) < $signed(lo_e.temp_low))
                    lo_e.temp_low = hi_e.temp_low;
                if (hi_e.power_high > lo_e.power_high)
                    lo_e.power_high = hi_e.power_high;
                if (hi_e.power_low < lo_e.power_low)
                    lo_e.power_low = hi_e.power_low;
                buckets[i] = lo_e;
            end
            count = HALF;
            res   = (res >= RES_HALF) ? RES_LIMIT : (res << 1);
            rev++;
        endfunction

        function void record_sample(logic [TIME_W-1:0] t, logic signed [TEMP_W-1:0] tc,
                                    logic [PWR_W-1:0] pw);
            int unsigned last;
            longint      diff;
            if (count == 0) begin
                open_bucket(t, tc, pw);
                return;
            end
            last = count - 1;
            diff = longint'(t) - longint'(buckets[last].start_time);
            if (diff < longint'(res)) begin
                if ($signed(tc) > $signed(buckets[last].temp_high))
                    buckets[last].temp_high = tc;
                if ($signed(tc) < $signed(buckets[last].temp_low))
                    buckets[last].temp_low = tc;
                if (pw > buckets[last].power_high)
                    buckets[last].power_high = pw;
                if (pw < buckets[last].power_low)
                    buckets[last].power_low = pw;
                return;
            end
            if (count >= CAPACITY)
                merge_pairs();
            open_bucket(t, tc, pw);
        endfunction

        function void note_command(logic [1:0] f, logic [TIME_W-1:0] t,
                                   logic signed [TEMP_W-1:0] tc, logic [PWR_W-1:0] pw,
                                   logic [7:0] idx);
            result_t                  owed;
            logic signed [TEMP_W-1:0] tc_sat;
            logic [PWR_W-1:0]         pw_sat;
            tc_sat = (tc == TEMP_NEG_RAW) ? TEMP_FLOOR : tc;
            pw_sat = (pw > POWER_MAX) ? POWER_MAX : pw;
            owed   = '0;
            accepted++;
            case (f)
                FUNC_RECORD: record_sample(t, tc_sat, pw_sat);
                FUNC_CLEAR:
                begin
                    count = 0;
                    res   = RES_INIT;
                    rev++;
                end
                FUNC_READ:
                begin
                    if (idx < count) begin
                        owed.read_valid = 1'b1;
                        owed.entry      = buckets[idx];
                    end
                end
                default: ;
            endcase
            owed.count      = CNT_W'(count);
            owed.resolution = res;
            owed.revision   = rev;
            owed_q = {owed_q, owed};
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t owed;
            if (owed_q.size() == 0) begin
                $error("result beat with no command outstanding");
                failures++;
                return;
            end
            owed = owed_q.pop_front();
            compare_field("read_valid", 32'(owed.read_valid), 32'(got.read_valid));
            compare_field("entry_time", 32'(owed.entry.start_time),
                          32'(got.entry.start_time));
            compare_field("entry_temp_high", 32'(owed.entry.temp_high),
                          32'(got.entry.temp_high));
            compare_field("entry_temp_low", 32'(owed.entry.temp_low),
                          32'(got.entry.temp_low));
            compare_field("entry_power_high", 32'(owed.entry.power_high),
                          32'(got.entry.power_high));
            compare_field("entry_power_low", 32'(owed.entry.power_low),
                          32'(got.entry.power_low));
            compare_field("bucket_count", 32'(owed.count), 32'(got.count));
            compare_field("seconds_per_bucket", 32'(owed.resolution), 32'(got.resolution));
            compare_field("history_revision", owed.revision, got.revision);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // clock, reset and block ports; every input starts at a known value
    logic clk;
    logic rst_n = 1'b0;

    logic                        in_valid      = 1'b0;
    logic                        in_ready;
    logic [1:0]                  func          = FUNC_RECORD;
    logic [TIME_W-1:0]           sample_time   = '0;
    logic signed [TEMP_W-1:0]    temperature   = '0;
    logic [PWR_W-1:0]            power_percent = '0;
    logic [7:0]                  read_index    = '0;
    logic                        out_valid;
    logic                        out_ready     = 1'b0;
    logic                        read_valid;
    logic [TIME_W-1:0]           entry_time;
    logic signed [TEMP_W-1:0]    entry_temp_high;
    logic signed [TEMP_W-1:0]    entry_temp_low;
    logic [PWR_W-1:0]            entry_power_high;
    logic [PWR_W-1:0]            entry_power_low;
    logic [CNT_W-1:0]            bucket_count;
    logic [TIME_W-1:0]           seconds_per_bucket;
    logic [REV_W-1:0]            history_revision;

    history_scoreboard sb = new();

    int unsigned cycle_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned idle_mode       = 1;
    bit          long_hold_done  = 1'b0;

    min_max_decimating_history DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .sample_time        (sample_time),
        .temperature        (temperature),
        .power_percent      (power_percent),
        .read_index         (read_index),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .read_valid         (read_valid),
        .entry_time         (entry_time),
        .entry_temp_high    (entry_temp_high),
        .entry_temp_low     (entry_temp_low),
        .entry_power_high   (entry_power_high),
        .entry_power_low    (entry_power_low),
        .bucket_count       (bucket_count),
        .seconds_per_bucket (seconds_per_bucket),
        .history_revision   (history_revision)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // hard stop in case the block hangs or drops a beat
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // idle behavior changes over the run: none, light, heavy
    initial
    begin
        forever
        begin
            repeat (300) @(posedge clk);
            idle_mode <= $urandom_range(0, 2);
        end
    end

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0)
            return 0;
        if (r < ((idle_mode == 1) ? 80 : 40))
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    // temperature with extra weight on the range ends and the raw -32768 code
    function automatic logic signed [TEMP_W-1:0] rand_temp();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return TEMP_NEG_RAW;
        if (r < 10)
            return TEMP_CEIL;
        if (r < 15)
            return TEMP_FLOOR;
        return TEMP_W'($urandom);
    endfunction

    // one command beat: optional idle gap, then hold valid until taken
    task automatic send_cmd(input logic [1:0] f, input logic [TIME_W-1:0] t,
                            input logic signed [TEMP_W-1:0] tc, input logic [PWR_W-1:0] pw,
                            input logic [7:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        sample_time   <= t;
        temperature   <= tc;
        power_percent <= pw;
        read_index    <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(f, t, tc, pw, idx);
        items_sent++;
    endtask

    // fields that the command ignores still carry random bits
    task automatic record_sample(input logic [TIME_W-1:0] t,
                                 input logic signed [TEMP_W-1:0] tc,
                                 input logic [PWR_W-1:0] pw);
        send_cmd(FUNC_RECORD, t, tc, pw, 8'($urandom));
    endtask

    task automatic read_bucket(input logic [7:0] idx);
        send_cmd(FUNC_READ, TIME_W'($urandom), TEMP_W'($urandom), PWR_W'($urandom), idx);
    endtask

    task automatic clear_history();
        send_cmd(FUNC_CLEAR, TIME_W'($urandom), TEMP_W'($urandom), PWR_W'($urandom),
                 8'($urandom));
    endtask

    task automatic send_unused();
        send_cmd(FUNC_UNUSED, TIME_W'($urandom), TEMP_W'($urandom), PWR_W'($urandom),
                 8'($urandom));
    endtask

    // receiver: random stalls plus one long hold-off so the block backs up
    // into its input while the sender keeps offering beats
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && sb.accepted >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else begin
                out_ready  <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // result monitor: sample at the edge where the beat is taken
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && out_valid && out_ready) begin
            got.read_valid       = read_valid;
            got.entry.start_time = entry_time;
            got.entry.temp_high  = entry_temp_high;
            got.entry.temp_low   = entry_temp_low;
            got.entry.power_high = entry_power_high;
            got.entry.power_low  = entry_power_low;
            got.count            = bucket_count;
            got.resolution       = seconds_per_bucket;
            got.revision         = history_revision;
            sb.check_result(got);
        end
    end

    // main sequence: reset, directed corner cases, random sampling sessions
    initial
    begin
        int unsigned ep;
        int unsigned ep_len;
        int unsigned open_pct;
        int unsigned r;
        longint      cur_t;
        longint      next_t;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // read of an empty store, first sample, widening with saturated inputs
        read_bucket(8'd0);
        record_sample(31'd100, 16'sd0, 7'd50);
        record_sample(31'd100, TEMP_NEG_RAW, 7'd127);
        // time going backwards still lands in the last bucket
        record_sample(31'd99, TEMP_CEIL, 7'd0);
        record_sample(31'd101, TEMP_FLOOR, 7'd101);
        record_sample(TIME_MAX, 16'sd1, 7'd100);
        record_sample(31'd0, -16'sd1, 7'd1);
        send_unused();
        read_bucket(8'd0);
        read_bucket(8'd1);
        read_bucket(8'd2);
        read_bucket(8'd3);
        read_bucket(8'd255);
        clear_history();
        read_bucket(8'd0);
        record_sample(31'd0, TEMP_CEIL, 7'd127);
        record_sample(31'd1, TEMP_NEG_RAW, 7'd0);
        record_sample(31'h5555_5555, -16'sd21846, 7'h55);
        record_sample(31'h2AAA_AAAA, 16'sd21845, 7'h2A);
        read_bucket(8'd0);
        read_bucket(8'd1);
        read_bucket(8'd2);
        send_unused();
        clear_history();
        read_bucket(8'd0);

        // random sessions: mostly a clear followed by a run of samples with
        // rising time so the store fills and merges; the first run is long
        // enough for several merges, the rest mix in noise and broken runs
        ep = 0;
        while (items_sent < TOTAL_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r != 0)
                clear_history();
            if (ep == 0 || r <= 2) begin
                ep_len   = $urandom_range(600, 900);
                open_pct = 95;
            end
            else begin
                ep_len   = $urandom_range(20, 200);
                open_pct = 60;
            end
            case ((ep == 0) ? 0 : $urandom_range(0, 2))
                0:       cur_t = $urandom_range(0, 1000);
                1:       cur_t = $urandom_range(0, 32'h7FF0_0000);
                default: cur_t = longint'(TIME_MAX) - $urandom_range(0, 20000);
            endcase
            for (int n = 0; n < ep_len && items_sent < TOTAL_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    // mostly in-range reads, some anywhere in the index space
                    if (sb.count > 0 && r < 10)
                        read_bucket(8'($urandom_range(0, sb.count - 1)));
                    else
                        read_bucket(8'($urandom_range(0, 255)));
                end
                else if (r < 14)
                    record_sample(TIME_W'($urandom), rand_temp(), PWR_W'($urandom));
                else if (r < 15)
                    send_unused();
                else if (r < 16)
                    clear_history();
                else begin
                    if ($urandom_range(0, 99) < open_pct)
                        next_t = cur_t + sb.res + $urandom_range(0, sb.res);
                    else if ($urandom_range(0, 9) == 0)
                        next_t = cur_t - $urandom_range(0, 50);
                    else
                        next_t = cur_t + $urandom_range(0, sb.res - 1);
                    // run ends when time would leave the field
                    if (next_t < 0 || next_t > longint'(TIME_MAX))
                        break;
                    cur_t = next_t;
                    record_sample(TIME_W'(cur_t), rand_temp(), PWR_W'($urandom));
                end
            end
            ep++;
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
